// File: sv/slmr_pkg.sv
// ----------------------------------------------------------------------------
// slmr_pkg: shared types and constants of the link message receiver
// Command codes, ring sizing, rate window constants, controller states and
// the word formats that pass between the receiver modules.
// ----------------------------------------------------------------------------
package slmr_pkg;

	// Receive ring sizing.
	localparam int unsigned RING_DEPTH = 1024;
	localparam int unsigned RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int unsigned RING_CW    = $clog2(RING_DEPTH + 1);

	typedef logic [RING_AW-1:0] slmr_ptr_t;
	typedef logic [RING_CW-1:0] slmr_cnt_t;

	localparam slmr_ptr_t RING_LAST     = slmr_ptr_t'(RING_DEPTH - 1);
	localparam slmr_cnt_t RING_CNT_FULL = slmr_cnt_t'(RING_DEPTH);

	// Field widths that are fixed by the link format.
	localparam int unsigned LRATE_W   = 22;
	localparam int unsigned PRATE_W   = 32;
	localparam int unsigned BCOUNT_W  = 11;
	localparam int unsigned LPROD_W   = 29;  // local rate times 110 fits here
	localparam int unsigned PPROD_W   = 39;  // peer rate times 100 fits here

	// Rate window: the peer rate must lie within 90..110 percent of ours.
	localparam logic [6:0] RATE_LO_PCT = 7'd90;
	localparam logic [6:0] RATE_HI_PCT = 7'd110;
	localparam logic [6:0] RATE_SCALE  = 7'd100;

	// Reset values.
	localparam int unsigned LOCAL_RATE_RST = 19200;
	localparam int unsigned PEER_RATE_RST  = 19200;
	localparam logic [LPROD_W-1:0] LRATE_LO_RST =
		LPROD_W'(LOCAL_RATE_RST * 90);
	localparam logic [LPROD_W-1:0] LRATE_HI_RST =
		LPROD_W'(LOCAL_RATE_RST * 110);
	localparam logic [PPROD_W-1:0] PRATE_SC_RST =
		PPROD_W'(PEER_RATE_RST * 100);
	localparam logic [7:0] LRATE_LSB_RST = 8'(LOCAL_RATE_RST % 256);
	localparam logic [7:0] PRATE_LSB_RST = 8'(PEER_RATE_RST % 256);
	localparam logic [7:0] CREDIT_RST    = 8'd3;

	// Link event codes.
	typedef enum logic [3:0] {
		CMD_DATA         = 4'd0,
		CMD_DATA_SYNC    = 4'd1,
		CMD_BLOCK_BYTE   = 4'd2,
		CMD_CMD_OFF      = 4'd3,
		CMD_CMD_OFF_SYNC = 4'd4,
		CMD_CMD_ON       = 4'd5,
		CMD_MOTOR_OFF    = 4'd6,
		CMD_MOTOR_ON     = 4'd7,
		CMD_SPEED        = 4'd8,
		CMD_CREDIT       = 4'd9,
		CMD_READ         = 4'd10,
		CMD_FLUSH        = 4'd11,
		CMD_TAKE_CREDIT  = 4'd12
	} slmr_cmd_t;

	// Controller states.
	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} slmr_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;  // latch the incoming event word
		logic commit;   // apply the event and load the status word
	} slmr_ctl_t;

	// One incoming event word.
	typedef struct packed {
		logic [3:0]         command;
		logic [7:0]         data_byte;
		logic [7:0]         sequence_number;
		logic               payload_complete;
		logic [PRATE_W-1:0] peer_rate;
		logic               last_in_block;
		logic [7:0]         credit_needed;
	} slmr_item_t;

	// One outgoing status word.
	typedef struct packed {
		logic                read_valid;
		logic [7:0]          read_data;
		logic                overrun;
		logic                command_line;
		logic                motor_line;
		logic                sync_pending;
		logic [7:0]          sync_number;
		logic [7:0]          credit_level;
		logic [BCOUNT_W-1:0] buffered_count;
		logic                credit_granted;
		logic                credit_request;
	} slmr_result_t;

endpackage

// File: sv/slmr_link_if.sv
// ----------------------------------------------------------------------------
// slmr_link_if: decoded link event channel
// Carries one decoded link event per word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface slmr_link_if;

	logic        valid;
	logic        ready;
	logic [3:0]  command;
	logic [7:0]  data_byte;
	logic [7:0]  sequence_number;
	logic        payload_complete;
	logic [31:0] peer_rate;
	logic        last_in_block;
	logic [7:0]  credit_needed;

	modport source (
		output valid, command, data_byte, sequence_number, payload_complete,
		       peer_rate, last_in_block, credit_needed,
		input  ready
	);

	modport sink (
		input  valid, command, data_byte, sequence_number, payload_complete,
		       peer_rate, last_in_block, credit_needed,
		output ready
	);

endinterface

// File: sv/slmr_status_if.sv
// ----------------------------------------------------------------------------
// slmr_status_if: receiver status channel
// Carries one status word per processed link event with a valid/ready
// handshake.
// ----------------------------------------------------------------------------
interface slmr_status_if;

	logic        valid;
	logic        ready;
	logic        read_valid;
	logic [7:0]  read_data;
	logic        overrun;
	logic        command_line;
	logic        motor_line;
	logic        sync_pending;
	logic [7:0]  sync_number;
	logic [7:0]  credit_level;
	logic [10:0] buffered_count;
	logic        credit_granted;
	logic        credit_request;

	modport source (
		output valid, read_valid, read_data, overrun, command_line, motor_line,
		       sync_pending, sync_number, credit_level, buffered_count,
		       credit_granted, credit_request,
		input  ready
	);

	modport sink (
		input  valid, read_valid, read_data, overrun, command_line, motor_line,
		       sync_pending, sync_number, credit_level, buffered_count,
		       credit_granted, credit_request,
		output ready
	);

endinterface

// File: sv/sio_link_message_receiver_unit.sv
// ----------------------------------------------------------------------------
// sio_link_message_receiver_unit: link message receiver top level
// Takes one decoded link event word on the link channel and returns one
// status word on the status channel. Data bytes go into a 1024-byte receive
// ring that overwrites its oldest byte when full; a byte is scrambled when the
// peer rate lies outside 90 to 110 percent of the local rate written through
// the configuration port. Each event has an acceptance cycle and an execute
// cycle, the latter set by the registered read of the ring memory at its
// tail pointer, so a new event is not taken until the last one has executed.
// The status word sits in an output register; a stalled status channel holds
// the execute cycle of the next event until the register frees. Configuration
// writes are taken in any cycle and must only be made while no event is in
// flight. No clearing pass is run after reset.
// ----------------------------------------------------------------------------
module sio_link_message_receiver_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [slmr_pkg::LRATE_W-1:0] cfg_wdata,
	slmr_link_if.sink                    link,
	slmr_status_if.source                status
);

	slmr_pkg::slmr_ctl_t    ctl;
	slmr_pkg::slmr_item_t   item;
	slmr_pkg::slmr_result_t res;

	// Gather the event word.
	assign item.command          = link.command;
	assign item.data_byte        = link.data_byte;
	assign item.sequence_number  = link.sequence_number;
	assign item.payload_complete = link.payload_complete;
	assign item.peer_rate        = link.peer_rate;
	assign item.last_in_block    = link.last_in_block;
	assign item.credit_needed    = link.credit_needed;

	// Sequencer.
	slmr_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.link_valid   (link.valid),
		.link_ready   (link.ready),
		.status_valid (status.valid),
		.status_ready (status.ready),
		.ctl          (ctl)
	);

	// Datapath.
	slmr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ctl       (ctl),
		.item      (item),
		.res       (res)
	);

	// Scatter the status word.
	assign status.read_valid     = res.read_valid;
	assign status.read_data      = res.read_data;
	assign status.overrun        = res.overrun;
	assign status.command_line   = res.command_line;
	assign status.motor_line     = res.motor_line;
	assign status.sync_pending   = res.sync_pending;
	assign status.sync_number    = res.sync_number;
	assign status.credit_level   = res.credit_level;
	assign status.buffered_count = res.buffered_count;
	assign status.credit_granted = res.credit_granted;
	assign status.credit_request = res.credit_request;

endmodule

// File: sv/slmr_ctrl.sv
// ----------------------------------------------------------------------------
// slmr_ctrl: receiver sequencer
// Takes one event word, runs its execute cycle once the status register is
// free, and tracks the status register's valid flag.
// ----------------------------------------------------------------------------
module slmr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                link_valid,
	output logic                link_ready,
	output logic                status_valid,
	input  logic                status_ready,
	output slmr_pkg::slmr_ctl_t ctl
);

	slmr_pkg::slmr_state_t state_q;
	slmr_pkg::slmr_state_t state_n;
	logic                  out_valid_q;
	logic                  out_free;

	// The status register can take a new word when empty or being drained.
	assign out_free = !out_valid_q || status_ready;

	// Next state.
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			slmr_pkg::ST_IDLE: begin
				if (link_valid) state_n = slmr_pkg::ST_EXEC;
			end
			slmr_pkg::ST_EXEC: begin
				if (out_free) state_n = slmr_pkg::ST_IDLE;
			end
			default: state_n = slmr_pkg::ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		link_ready  = 1'b0;
		ctl.capture = 1'b0;
		ctl.commit  = 1'b0;
		unique case (state_q)
			slmr_pkg::ST_IDLE: begin
				link_ready  = 1'b1;
				ctl.capture = link_valid;
			end
			slmr_pkg::ST_EXEC: begin
				ctl.commit = out_free;
			end
			default: begin
				link_ready = 1'b0;
			end
		endcase
	end

	assign status_valid = out_valid_q;

	// State register and status valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= slmr_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (ctl.commit) begin
				out_valid_q <= 1'b1;
			end else if (status_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: sv/slmr_dp.sv
// ----------------------------------------------------------------------------
// slmr_dp: receiver datapath
// Holds the event register, the receive ring memory with its pointers, the
// line, sync, rate and credit state, and the status word register.
// ----------------------------------------------------------------------------
module slmr_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [slmr_pkg::LRATE_W-1:0]       cfg_wdata,
	input  slmr_pkg::slmr_ctl_t                ctl,
	input  slmr_pkg::slmr_item_t               item,
	output slmr_pkg::slmr_result_t             res
);

	// Event register.
	slmr_pkg::slmr_item_t item_q;

	// Ring memory and its control.
	logic [7:0]          ring_mem [slmr_pkg::RING_DEPTH];
	logic [7:0]          rd_data_q;
	slmr_pkg::slmr_ptr_t head_q, head_n, head_inc;
	slmr_pkg::slmr_ptr_t tail_q, tail_n, tail_inc;
	slmr_pkg::slmr_cnt_t cnt_q, cnt_n;
	logic                full_q, full_n;
	logic                ring_empty;
	logic                store_req;
	logic                wr_en;
	logic [7:0]          store_byte;

	// Line, sync and credit state.
	logic       cmd_line_q, cmd_line_n;
	logic       motor_q, motor_n;
	logic       sync_valid_q, sync_valid_n;
	logic [7:0] sync_value_q, sync_value_n;
	logic [7:0] credit_q, credit_n;

	// Rate window: scaled local bounds and scaled peer rate.
	logic [slmr_pkg::LPROD_W-1:0] lrate_lo_q;
	logic [slmr_pkg::LPROD_W-1:0] lrate_hi_q;
	logic [7:0]                   lrate_lsb_q;
	logic [slmr_pkg::PPROD_W-1:0] prate_sc_q;
	logic [7:0]                   prate_lsb_q;
	logic                         peer_load;
	logic                         rate_bad;
	logic [slmr_pkg::PPROD_W:0]   prate_sc_inc;

	// Status word pieces.
	slmr_pkg::slmr_result_t                     res_n;
	slmr_pkg::slmr_result_t                     res_q;
	logic [slmr_pkg::RING_CW+slmr_pkg::BCOUNT_W-1:0] cnt_wide;
	slmr_pkg::slmr_cnt_t                        ptr_dist;

	// Capture the event word at acceptance.
	always_ff @(posedge clk) begin
		if (ctl.capture) item_q <= item;
	end

	// Pointer increments wrap at the ring depth.
	assign head_inc   = (head_q == slmr_pkg::RING_LAST) ? '0 : head_q + 1'b1;
	assign tail_inc   = (tail_q == slmr_pkg::RING_LAST) ? '0 : tail_q + 1'b1;
	assign ring_empty = (head_q == tail_q) && !full_q;

	// The peer rate is outside the window when
	// 100*peer + 100 <= 90*local, or 110*local < 100*peer.
	assign prate_sc_inc = {1'b0, prate_sc_q}
		+ {{(slmr_pkg::PPROD_W - 6){1'b0}}, slmr_pkg::RATE_SCALE};
	assign rate_bad =
		(prate_sc_inc <= {{(slmr_pkg::PPROD_W + 1 - slmr_pkg::LPROD_W){1'b0}}, lrate_lo_q})
		|| ({{(slmr_pkg::PPROD_W - slmr_pkg::LPROD_W){1'b0}}, lrate_hi_q} < prate_sc_q);

	assign store_byte = rate_bad ? (item_q.data_byte ^ prate_lsb_q ^ lrate_lsb_q)
		: item_q.data_byte;

	// Event decode and next state.
	always_comb begin
		head_n       = head_q;
		tail_n       = tail_q;
		full_n       = full_q;
		cnt_n        = cnt_q;
		cmd_line_n   = cmd_line_q;
		motor_n      = motor_q;
		sync_valid_n = sync_valid_q;
		sync_value_n = sync_value_q;
		credit_n     = credit_q;
		store_req    = 1'b0;
		peer_load    = 1'b0;
		res_n        = '0;

		unique case (slmr_pkg::slmr_cmd_t'(item_q.command))
			slmr_pkg::CMD_DATA: begin
				store_req = 1'b1;
			end
			slmr_pkg::CMD_DATA_SYNC: begin
				if (item_q.payload_complete) begin
					sync_valid_n = 1'b1;
					sync_value_n = item_q.sequence_number;
				end
				store_req = 1'b1;
			end
			slmr_pkg::CMD_BLOCK_BYTE: begin
				store_req = !item_q.last_in_block;
			end
			slmr_pkg::CMD_CMD_OFF: begin
				cmd_line_n = 1'b0;
			end
			slmr_pkg::CMD_CMD_OFF_SYNC: begin
				if (item_q.payload_complete) begin
					sync_valid_n = 1'b1;
					sync_value_n = item_q.sequence_number;
				end
				cmd_line_n = 1'b0;
			end
			slmr_pkg::CMD_CMD_ON: begin
				cmd_line_n   = 1'b1;
				sync_valid_n = 1'b0;
				tail_n       = head_q;
				full_n       = 1'b0;
				cnt_n        = '0;
			end
			slmr_pkg::CMD_MOTOR_OFF: begin
				motor_n = 1'b0;
			end
			slmr_pkg::CMD_MOTOR_ON: begin
				motor_n = 1'b1;
			end
			slmr_pkg::CMD_SPEED: begin
				peer_load = item_q.payload_complete;
			end
			slmr_pkg::CMD_CREDIT: begin
				credit_n = item_q.data_byte;
			end
			slmr_pkg::CMD_READ: begin
				if (!ring_empty) begin
					res_n.read_valid = 1'b1;
					res_n.read_data  = rd_data_q;
					tail_n           = tail_inc;
					full_n           = 1'b0;
					cnt_n            = cnt_q - 1'b1;
				end
			end
			slmr_pkg::CMD_FLUSH: begin
				tail_n = head_q;
				full_n = 1'b0;
				cnt_n  = '0;
			end
			slmr_pkg::CMD_TAKE_CREDIT: begin
				if (item_q.credit_needed > credit_q) begin
					res_n.credit_request = 1'b1;
				end else begin
					credit_n             = credit_q - item_q.credit_needed;
					res_n.credit_granted = 1'b1;
				end
			end
			default: begin
				store_req = 1'b0;
			end
		endcase

		// A stored byte advances the head; on a full ring it pushes the tail.
		if (store_req) begin
			head_n = head_inc;
			if (full_q) begin
				tail_n        = head_inc;
				res_n.overrun = 1'b1;
			end else begin
				full_n = (head_inc == tail_q);
				cnt_n  = cnt_q + 1'b1;
			end
		end

		res_n.command_line   = cmd_line_n;
		res_n.motor_line     = motor_n;
		res_n.sync_pending   = sync_valid_n;
		res_n.sync_number    = sync_valid_n ? sync_value_n : 8'd0;
		res_n.credit_level   = credit_n;
		res_n.buffered_count = cnt_wide[slmr_pkg::BCOUNT_W-1:0];
	end

	assign cnt_wide = {{slmr_pkg::BCOUNT_W{1'b0}}, cnt_n};
	assign wr_en    = ctl.commit && store_req;

	// Ring memory: one write port at the head, registered read at the tail.
	always_ff @(posedge clk) begin
		if (wr_en) ring_mem[head_q] <= store_byte;
		rd_data_q <= ring_mem[tail_q];
	end

	// Control and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			tail_q       <= '0;
			full_q       <= 1'b0;
			cnt_q        <= '0;
			cmd_line_q   <= 1'b0;
			motor_q      <= 1'b0;
			sync_valid_q <= 1'b0;
			sync_value_q <= 8'd0;
			credit_q     <= slmr_pkg::CREDIT_RST;
			prate_sc_q   <= slmr_pkg::PRATE_SC_RST;
			prate_lsb_q  <= slmr_pkg::PRATE_LSB_RST;
			lrate_lo_q   <= slmr_pkg::LRATE_LO_RST;
			lrate_hi_q   <= slmr_pkg::LRATE_HI_RST;
			lrate_lsb_q  <= slmr_pkg::LRATE_LSB_RST;
		end else begin
			if (ctl.commit) begin
				head_q       <= head_n;
				tail_q       <= tail_n;
				full_q       <= full_n;
				cnt_q        <= cnt_n;
				cmd_line_q   <= cmd_line_n;
				motor_q      <= motor_n;
				sync_valid_q <= sync_valid_n;
				sync_value_q <= sync_value_n;
				credit_q     <= credit_n;
				if (peer_load) begin
					prate_sc_q  <= {{(slmr_pkg::PPROD_W - slmr_pkg::PRATE_W){1'b0}},
						item_q.peer_rate}
						* {{(slmr_pkg::PPROD_W - 7){1'b0}}, slmr_pkg::RATE_SCALE};
					prate_lsb_q <= item_q.peer_rate[7:0];
				end
			end
			// Local rate writes keep only the scaled bounds and the low byte.
			if (cfg_we) begin
				lrate_lo_q  <= {{(slmr_pkg::LPROD_W - slmr_pkg::LRATE_W){1'b0}}, cfg_wdata}
					* {{(slmr_pkg::LPROD_W - 7){1'b0}}, slmr_pkg::RATE_LO_PCT};
				lrate_hi_q  <= {{(slmr_pkg::LPROD_W - slmr_pkg::LRATE_W){1'b0}}, cfg_wdata}
					* {{(slmr_pkg::LPROD_W - 7){1'b0}}, slmr_pkg::RATE_HI_PCT};
				lrate_lsb_q <= cfg_wdata[7:0];
			end
		end
	end

	// Status word register.
	always_ff @(posedge clk) begin
		if (ctl.commit) res_q <= res_n;
	end

	assign res = res_q;

	// Fill level implied by the pointers when the ring is not full.
	assign ptr_dist = (head_q >= tail_q)
		? (slmr_pkg::slmr_cnt_t'(head_q) - slmr_pkg::slmr_cnt_t'(tail_q))
		: (slmr_pkg::slmr_cnt_t'(head_q) + slmr_pkg::RING_CNT_FULL
			- slmr_pkg::slmr_cnt_t'(tail_q));

	// A full ring has meeting pointers and a full count.
	a_full_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |-> (head_q == tail_q) && (cnt_q == slmr_pkg::RING_CNT_FULL))
		else $error("ring full flag disagrees with pointers or count");

	// The count tracks the pointer distance whenever the ring is not full.
	a_cnt_dist: assert property (@(posedge clk) disable iff (!arst_n)
		!full_q |-> (cnt_q == ptr_dist))
		else $error("ring count disagrees with pointer distance");

	// An overrun only happens on a full ring, and the ring stays full.
	a_overrun_full: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.commit && res_n.overrun) |=> full_q)
		else $error("overrun reported while the ring was not full");

	// A credit take is either granted or requested, never both.
	a_credit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |-> !(res_n.credit_granted && res_n.credit_request))
		else $error("credit granted and requested together");

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the link message receiver
// Feeds decoded link events through the link channel, predicts each status
// word from a behavioral copy of the receive ring, lines, sync hold and
// credit, and checks every word on the status channel field by field. Both
// channels idle at random. The local rate is rewritten between phases,
// including its extremes.
// ----------------------------------------------------------------------------
module tb;

	// Widths and sizes taken from the package.
	localparam int unsigned LRATE_W    = slmr_pkg::LRATE_W;
	localparam int unsigned PRATE_W    = slmr_pkg::PRATE_W;
	localparam int unsigned BCOUNT_W   = slmr_pkg::BCOUNT_W;
	localparam int unsigned RING_DEPTH = slmr_pkg::RING_DEPTH;

	// Command codes that the receiver ignores.
	localparam logic [3:0] CMD_UNDEF_LO = 4'd13;
	localparam logic [3:0] CMD_UNDEF_HI = 4'd15;

	// Rate window in percent of the local rate.
	localparam longint unsigned WIN_LO_PCT = 90;
	localparam longint unsigned WIN_HI_PCT = 110;
	localparam longint unsigned WIN_SCALE  = 100;

	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned SETTLE      = 8;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [LRATE_W-1:0]  cfg_wdata;

	slmr_link_if   link_ch();
	slmr_status_if stat_ch();

	sio_link_message_receiver_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.link      (link_ch),
		.status    (stat_ch)
	);

	// Clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Behavioral copy of the receiver state.
	logic [7:0]         rx_ring [RING_DEPTH];
	int unsigned        rx_head = 0;
	int unsigned        rx_tail = 0;
	bit                 rx_full = 1'b0;
	bit                 cmd_line_q = 1'b0;
	bit                 motor_q = 1'b0;
	bit                 sync_held = 1'b0;
	logic [7:0]         sync_num = 8'd0;
	logic [PRATE_W-1:0] peer_baud = PRATE_W'(slmr_pkg::PEER_RATE_RST);
	logic [7:0]         credit_q = 8'd3;
	logic [LRATE_W-1:0] local_baud = LRATE_W'(slmr_pkg::LOCAL_RATE_RST);

	slmr_pkg::slmr_item_t   link_backlog [$];
	slmr_pkg::slmr_result_t status_due [$];
	slmr_pkg::slmr_item_t   cur_event;

	int          mismatches = 0;
	int unsigned cycles = 0;
	int unsigned drv_gap;
	int unsigned mon_stall;
	int unsigned hold;
	bit          steady = 1'b0;

	// Stores one byte at the ring head, scrambled when the peer rate is out
	// of the window. Returns whether the oldest byte was overwritten.
	function automatic bit push_byte(logic [7:0] b);
		longint unsigned lo, hi;
		lo = (64'(local_baud) * WIN_LO_PCT) / WIN_SCALE;
		hi = (64'(local_baud) * WIN_HI_PCT) / WIN_SCALE;
		if (64'(peer_baud) < lo || 64'(peer_baud) > hi)
			b = b ^ peer_baud[7:0] ^ local_baud[7:0];
		rx_ring[rx_head] = b;
		rx_head = (rx_head + 1) % RING_DEPTH;
		if (rx_full) begin
			rx_tail = rx_head;
			return 1'b1;
		end
		rx_full = (rx_head == rx_tail);
		return 1'b0;
	endfunction

	// Applies one link event and returns the status word it yields.
	function automatic slmr_pkg::slmr_result_t predict_status(slmr_pkg::slmr_item_t ev);
		slmr_pkg::slmr_result_t st;
		int unsigned            level;
		st = '0;
		case (ev.command)
			slmr_pkg::CMD_DATA_SYNC: begin
				if (ev.payload_complete) begin
					sync_held = 1'b1;
					sync_num  = ev.sequence_number;
				end
				st.overrun = push_byte(ev.data_byte);
			end
			slmr_pkg::CMD_DATA: st.overrun = push_byte(ev.data_byte);
			slmr_pkg::CMD_BLOCK_BYTE: begin
				if (!ev.last_in_block)
					st.overrun = push_byte(ev.data_byte);
			end
			slmr_pkg::CMD_CMD_OFF_SYNC: begin
				if (ev.payload_complete) begin
					sync_held = 1'b1;
					sync_num  = ev.sequence_number;
				end
				cmd_line_q = 1'b0;
			end
			slmr_pkg::CMD_CMD_OFF: cmd_line_q = 1'b0;
			slmr_pkg::CMD_CMD_ON: begin
				cmd_line_q = 1'b1;
				sync_held  = 1'b0;
				rx_tail    = rx_head;
				rx_full    = 1'b0;
			end
			slmr_pkg::CMD_MOTOR_OFF: motor_q = 1'b0;
			slmr_pkg::CMD_MOTOR_ON: motor_q = 1'b1;
			slmr_pkg::CMD_SPEED: begin
				if (ev.payload_complete)
					peer_baud = ev.peer_rate;
			end
			slmr_pkg::CMD_CREDIT: credit_q = ev.data_byte;
			slmr_pkg::CMD_READ: begin
				if (rx_head != rx_tail || rx_full) begin
					st.read_valid = 1'b1;
					st.read_data  = rx_ring[rx_tail];
					rx_tail = (rx_tail + 1) % RING_DEPTH;
					rx_full = 1'b0;
				end
			end
			slmr_pkg::CMD_FLUSH: begin
				rx_tail = rx_head;
				rx_full = 1'b0;
			end
			slmr_pkg::CMD_TAKE_CREDIT: begin
				if (ev.credit_needed > credit_q) begin
					st.credit_request = 1'b1;
				end else begin
					credit_q = credit_q - ev.credit_needed;
					st.credit_granted = 1'b1;
				end
			end
			default: ;
		endcase
		if (rx_full)
			level = RING_DEPTH;
		else
			level = (rx_head + RING_DEPTH - rx_tail) % RING_DEPTH;
		st.command_line   = cmd_line_q;
		st.motor_line     = motor_q;
		st.sync_pending   = sync_held;
		st.sync_number    = sync_held ? sync_num : 8'd0;
		st.credit_level   = credit_q;
		st.buffered_count = BCOUNT_W'(level);
		return st;
	endfunction

	function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			mismatches++;
		end
	endfunction

	// Idle length for either channel: mostly short, a few long, none while
	// a steady stretch is running.
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (steady)
			return 0;
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic void queue_event(logic [3:0] code, logic [7:0] dbyte, logic [7:0] seq,
			logic complete, logic [31:0] rate, logic last, logic [7:0] need);
		slmr_pkg::slmr_item_t ev;
		ev.command          = code;
		ev.data_byte        = dbyte;
		ev.sequence_number  = seq;
		ev.payload_complete = complete;
		ev.peer_rate        = rate;
		ev.last_in_block    = last;
		ev.credit_needed    = need;
		link_backlog.push_back(ev);
	endfunction

	// Random content for one event; speed changes land near the local rate
	// half the time so that both sides of the window are hit.
	function automatic void queue_random(logic [3:0] code);
		logic [31:0] rate;
		logic [7:0]  need;
		rate = $urandom;
		need = 8'($urandom);
		if (code == slmr_pkg::CMD_SPEED && $urandom_range(0, 1))
			rate = 32'((64'(local_baud) * $urandom_range(85, 115)) / WIN_SCALE);
		if (code == slmr_pkg::CMD_TAKE_CREDIT && $urandom_range(0, 1))
			need = 8'($urandom_range(0, 7));
		queue_event(code, 8'($urandom), 8'($urandom), 1'($urandom), rate,
			(code == slmr_pkg::CMD_BLOCK_BYTE) ? ($urandom_range(0, 15) == 0)
				: 1'($urandom), need);
	endfunction

	// Waits until no word is queued, in flight or expected, then settles.
	// The check runs at the falling edge, after the rising edge has settled.
	task automatic drain();
		while (link_backlog.size() != 0 || link_ch.valid || status_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_local_baud(logic [LRATE_W-1:0] v);
		@(posedge clk);
		cfg_we     <= 1'b1;
		cfg_wdata  <= v;
		local_baud = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Toggles steady stretches in which neither side idles.
	always @(posedge clk) begin
		if ($urandom_range(0, 399) == 0)
			steady <= !steady;
	end

	// Link driver: takes words from the backlog and holds each until accepted.
	always @(posedge clk) begin
		if (!arst_n) begin
			link_ch.valid            <= 1'b0;
			link_ch.command          <= '0;
			link_ch.data_byte        <= '0;
			link_ch.sequence_number  <= '0;
			link_ch.payload_complete <= 1'b0;
			link_ch.peer_rate        <= '0;
			link_ch.last_in_block    <= 1'b0;
			link_ch.credit_needed    <= '0;
			drv_gap                  <= 0;
		end else begin
			if (link_ch.valid && link_ch.ready)
				status_due.push_back(predict_status(cur_event));
			if (!link_ch.valid || link_ch.ready) begin
				if (drv_gap != 0) begin
					drv_gap       <= drv_gap - 1;
					link_ch.valid <= 1'b0;
				end else if (link_backlog.size() != 0) begin
					cur_event = link_backlog.pop_front();
					link_ch.command          <= cur_event.command;
					link_ch.data_byte        <= cur_event.data_byte;
					link_ch.sequence_number  <= cur_event.sequence_number;
					link_ch.payload_complete <= cur_event.payload_complete;
					link_ch.peer_rate        <= cur_event.peer_rate;
					link_ch.last_in_block    <= cur_event.last_in_block;
					link_ch.credit_needed    <= cur_event.credit_needed;
					link_ch.valid            <= 1'b1;
					drv_gap                  <= idle_len();
				end else begin
					link_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Status monitor: checks each accepted word and stalls at random.
	always @(posedge clk) begin
		if (!arst_n) begin
			stat_ch.ready <= 1'b0;
			mon_stall     <= 0;
		end else begin
			if (stat_ch.valid && stat_ch.ready) begin
				if (status_due.size() == 0) begin
					$error("status word with no link event waiting");
					mismatches++;
				end else begin
					slmr_pkg::slmr_result_t want;
					want = status_due.pop_front();
					check_field("read_valid", want.read_valid, stat_ch.read_valid);
					check_field("read_data", want.read_data, stat_ch.read_data);
					check_field("overrun", want.overrun, stat_ch.overrun);
					check_field("command_line", want.command_line, stat_ch.command_line);
					check_field("motor_line", want.motor_line, stat_ch.motor_line);
					check_field("sync_pending", want.sync_pending, stat_ch.sync_pending);
					check_field("sync_number", want.sync_number, stat_ch.sync_number);
					check_field("credit_level", want.credit_level, stat_ch.credit_level);
					check_field("buffered_count", want.buffered_count,
						stat_ch.buffered_count);
					check_field("credit_granted", want.credit_granted,
						stat_ch.credit_granted);
					check_field("credit_request", want.credit_request,
						stat_ch.credit_request);
				end
			end
			if (mon_stall != 0) begin
				mon_stall     <= mon_stall - 1;
				stat_ch.ready <= 1'b0;
			end else if ((stat_ch.valid && stat_ch.ready) || $urandom_range(0, 15) == 0) begin
				hold = idle_len();
				mon_stall     <= hold;
				stat_ch.ready <= (hold == 0);
			end else begin
				stat_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Stimulus and end of run.
	initial begin
		logic [LRATE_W-1:0] rate;
		logic [3:0]         code;
		bit                 fill;
		int unsigned        count;
		int unsigned        r;

		arst_n    = 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;

		// Directed part at the reset rate, peer rate both inside and outside the window.
		queue_event(slmr_pkg::CMD_READ, 8'h00, 8'h00, 1'b0, 32'd0, 1'b0, 8'h00);
		queue_event(slmr_pkg::CMD_DATA, 8'h00, 8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 8'hFF);
		queue_event(slmr_pkg::CMD_DATA, 8'hFF, 8'h00, 1'b0, 32'd0, 1'b0, 8'h00);
		queue_event(slmr_pkg::CMD_DATA_SYNC, 8'h81, 8'hA5, 1'b1, 32'd0, 1'b0, 8'h00);
		queue_event(slmr_pkg::CMD_DATA_SYNC, 8'h42, 8'h5A, 1'b0, 32'd0, 1'b0, 8'h00);
		queue_event(slmr_pkg::CMD_BLOCK_BYTE, 8'h3C, 8'h00, 1'b0, 32'd0, 1'b0, 8'h00);
		queue_event(slmr_pkg::CMD_BLOCK_BYTE, 8'h77, 8'h00, 1'b0, 32'd0, 1'b1, 8'h00);
		queue_event(slmr_pkg::CMD_CMD_OFF_SYNC, 8'h00, 8'hFF, 1'b1, 32'd0, 1'b0, 8'h00);
		queue_event(slmr_pkg::CMD_CMD_OFF_SYNC, 8'h00, 8'h00, 1'b0, 32'd0, 1'b0, 8'h00);
		queue_event(slmr_pkg::CMD_MOTOR_ON, 8'h00, 8'h00, 1'b0, 32'd0, 1'b0, 8'h00);
		queue_event(slmr_pkg::CMD_MOTOR_OFF, 8'h00, 8'h00, 1'b0, 32'd0, 1'b0, 8'h00);
		queue_event(slmr_pkg::CMD_SPEED, 8'h00, 8'h00, 1'b1, 32'hFFFF_FFFF, 1'b0, 8'h00);
		queue_event(slmr_pkg::CMD_DATA, 8'h12, 8'h00, 1'b0, 32'd0, 1'b0, 8'h00);
		queue_event(slmr_pkg::CMD_SPEED, 8'h00, 8'h00, 1'b0, 32'd0, 1'b0, 8'h00);
		// Window edges: exactly 110 percent is in, one above is out.
		queue_event(slmr_pkg::CMD_SPEED, 8'h00, 8'h00, 1'b1, 32'd21120, 1'b0, 8'h00);
		queue_event(slmr_pkg::CMD_DATA, 8'h34, 8'h00, 1'b0, 32'd0, 1'b0, 8'h00);
		queue_event(slmr_pkg::CMD_SPEED, 8'h00, 8'h00, 1'b1, 32'd21121, 1'b0, 8'h00);
		queue_event(slmr_pkg::CMD_DATA, 8'h56, 8'h00, 1'b0, 32'd0, 1'b0, 8'h00);
		queue_event(slmr_pkg::CMD_SPEED, 8'h00, 8'h00, 1'b1, 32'd17280, 1'b0, 8'h00);
		queue_event(slmr_pkg::CMD_READ, 8'h00, 8'h00, 1'b0, 32'd0, 1'b0, 8'h00);
		queue_event(slmr_pkg::CMD_TAKE_CREDIT, 8'h00, 8'h00, 1'b0, 32'd0, 1'b0, 8'h04);
		queue_event(slmr_pkg::CMD_TAKE_CREDIT, 8'h00, 8'h00, 1'b0, 32'd0, 1'b0, 8'h03);
		queue_event(slmr_pkg::CMD_TAKE_CREDIT, 8'h00, 8'h00, 1'b0, 32'd0, 1'b0, 8'h00);
		queue_event(slmr_pkg::CMD_CREDIT, 8'hFF, 8'h00, 1'b0, 32'd0, 1'b0, 8'h00);
		queue_event(slmr_pkg::CMD_TAKE_CREDIT, 8'h00, 8'h00, 1'b0, 32'd0, 1'b0, 8'hFF);
		queue_event(slmr_pkg::CMD_CMD_ON, 8'h00, 8'h00, 1'b0, 32'd0, 1'b0, 8'h00);
		queue_event(slmr_pkg::CMD_FLUSH, 8'h00, 8'h00, 1'b0, 32'd0, 1'b0, 8'h00);
		queue_event(CMD_UNDEF_LO, 8'hFF, 8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 8'hFF);
		queue_event(CMD_UNDEF_HI, 8'h00, 8'h00, 1'b0, 32'd0, 1'b0, 8'h00);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		drain();

		// Random phases: the first two fill the ring past full, the rest mix
		// every command with frequent reads and clears.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: rate = LRATE_W'(4000000);
				1: rate = LRATE_W'(300);
				2: rate = '1;
				3: rate = '0;
				default: rate = LRATE_W'($urandom_range(300, 4000000));
			endcase
			fill  = (ph < 2);
			count = fill ? 575 : 45;
			write_local_baud(rate);
			for (int n = 0; n < count; n++) begin
				r = $urandom_range(0, 99);
				if (fill) begin
					if (r != 0) begin
						code = 4'($urandom_range(slmr_pkg::CMD_DATA,
							slmr_pkg::CMD_BLOCK_BYTE));
					end else begin
						code = 4'($urandom_range(slmr_pkg::CMD_CMD_OFF,
							slmr_pkg::CMD_CREDIT));
						if (code == slmr_pkg::CMD_CMD_ON)
							code = slmr_pkg::CMD_SPEED;
					end
				end else if (r < 30) begin
					code = slmr_pkg::CMD_READ;
				end else if (r < 55) begin
					code = 4'($urandom_range(slmr_pkg::CMD_DATA, slmr_pkg::CMD_BLOCK_BYTE));
				end else begin
					code = 4'($urandom_range(slmr_pkg::CMD_DATA, CMD_UNDEF_HI));
				end
				queue_random(code);
			end
			drain();
		end

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: filelist.f
sv/slmr_pkg.sv
sv/slmr_link_if.sv
sv/slmr_status_if.sv
sv/slmr_ctrl.sv
sv/slmr_dp.sv
sv/sio_link_message_receiver_unit.sv
verif/tb.sv
